### rtl/core/tcw_pkg.sv
package tcw_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_DEFAULT_ATTR = 1'b0;
    localparam logic REG_CURSOR_ATTR  = 1'b1;

    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd7;
    localparam logic [7:0] CURSOR_ATTR_RESET  = 8'hFF;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } tcw_in_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_column_out;
        logic        scrolled;
    } tcw_out_t;

    typedef struct packed {
        logic [7:0] default_attribute;
        logic [7:0] cursor_attribute;
    } tcw_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_FINISH
    } tcw_state_t;

endpackage

### rtl/core/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/tcw_cfg.sv
module tcw_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tcw_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output tcw_pkg::tcw_cfg_t              cfg
);

    import tcw_pkg::*;

    tcw_cfg_t cfg_reg;
    logic     wr_en;
    logic     reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_attribute <= DEFAULT_ATTR_RESET;
            cfg_reg.cursor_attribute  <= CURSOR_ATTR_RESET;
        end else if (wr_en) begin
            if (reg_sel == REG_CURSOR_ATTR) begin
                cfg_reg.cursor_attribute <= pwdata[7:0];
            end else begin
                cfg_reg.default_attribute <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_CURSOR_ATTR) begin
            prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_reg.cursor_attribute};
        end else begin
            prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_reg.default_attribute};
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/text_console_writer.sv
// Reads, cursor moves and ordinary characters go from accept through ST_EXEC to ST_FINISH,
// which registers the result and stalls while the output holds an untaken one; the next
// item can be accepted in ST_FINISH. A scroll runs ST_SCROLL (one cell written per cycle),
// a clear runs ST_CLEAR. Reset (synchronous, active low) runs a clearing pass that blanks
// the screen and draws the cursor at the origin; no item is accepted until it ends.
module text_console_writer #(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tcw_pkg::tcw_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tcw_pkg::tcw_out_t              m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tcw_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    import tcw_pkg::*;

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int MOVED = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLUMNS);

    tcw_cfg_t cfg;

    tcw_state_t       state_reg, state_next;
    tcw_in_t          in_reg, in_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [15:0]      saved_reg, saved_next;
    logic             report_reg, report_next;
    logic             scrolled_reg, scrolled_next;
    logic             fwd_reg, fwd_next;
    logic             rvalid_reg, rvalid_next;
    logic [AW-1:0]    raddr_reg, raddr_next;
    logic             m_valid_reg, m_valid_next;
    tcw_out_t         m_data_reg, m_data_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [15:0]      ram_wdata;
    logic [15:0]      ram_rdata;

    logic [15:0]      blank;
    logic             ordinary;
    logic             out_free;
    logic             complete;
    logic [AW-1:0]    line_addr;
    logic [RW:0]      row_inc;

    tcw_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr_next),
        .rdata (ram_rdata)
    );

    assign blank     = {cfg.default_attribute, CH_SPACE};
    assign ordinary  = (in_reg.char_code != CH_NEWLINE) && (in_reg.char_code != CH_RETURN);
    assign out_free  = !m_valid_reg || m_ready;
    assign complete  = !report_reg || out_free;
    assign line_addr = addr_reg - AW'(col_reg);
    assign row_inc   = {1'b0, row_reg} + (RW+1)'(1);

    assign s_ready = (state_reg == ST_IDLE) || (state_reg == ST_FINISH && complete);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_CLEAR;
            in_reg                <= '{operation: OP_CLEAR, char_code: 8'd0,
                                       read_row: 5'd0, read_column: 7'd0};
            cnt_reg               <= '0;
            row_reg               <= '0;
            col_reg               <= '0;
            addr_reg              <= '0;
            report_reg            <= 1'b0;
            scrolled_reg          <= 1'b0;
            fwd_reg               <= 1'b0;
            rvalid_reg            <= 1'b0;
            raddr_reg             <= '0;
            m_valid_reg           <= 1'b0;
        end else begin
            state_reg             <= state_next;
            in_reg                <= in_next;
            cnt_reg               <= cnt_next;
            row_reg               <= row_next;
            col_reg               <= col_next;
            addr_reg              <= addr_next;
            report_reg            <= report_next;
            scrolled_reg          <= scrolled_next;
            fwd_reg               <= fwd_next;
            rvalid_reg            <= rvalid_next;
            raddr_reg             <= raddr_next;
            m_valid_reg           <= m_valid_next;
        end
        saved_reg  <= saved_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        in_next       = in_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        addr_next     = addr_reg;
        saved_next    = saved_reg;
        report_next   = report_reg;
        scrolled_next = scrolled_reg;
        fwd_next      = fwd_reg;
        rvalid_next   = rvalid_reg;
        raddr_next    = raddr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = saved_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                scrolled_next = 1'b0;
                fwd_next      = 1'b0;
                case (in_reg.operation)
                    OP_WRITE: begin
                        ram_we    = 1'b1;
                        ram_wdata = ordinary ? {cfg.default_attribute, in_reg.char_code}
                                             : saved_reg;
                        if (in_reg.char_code == CH_RETURN) begin
                            col_next  = '0;
                            addr_next = line_addr;
                        end else if (in_reg.char_code == CH_NEWLINE) begin
                            col_next  = '0;
                            row_next  = row_inc[RW-1:0];
                            addr_next = line_addr + AW'(SCREEN_COLUMNS);
                        end else if (col_reg == CW'(SCREEN_COLUMNS - 1)) begin
                            col_next  = '0;
                            row_next  = row_inc[RW-1:0];
                            addr_next = addr_reg + AW'(1);
                        end else begin
                            col_next  = col_reg + CW'(1);
                            addr_next = addr_reg + AW'(1);
                        end
                        if (!(ordinary && col_reg != CW'(SCREEN_COLUMNS - 1))
                            && in_reg.char_code != CH_RETURN
                            && row_inc == (RW+1)'(SCREEN_ROWS)) begin
                            row_next      = RW'(SCREEN_ROWS - 1);
                            col_next      = '0;
                            addr_next     = AW'(MOVED);
                            scrolled_next = 1'b1;
                            cnt_next      = '0;
                            state_next    = ST_SCROLL;
                        end else begin
                            raddr_next = addr_next;
                            fwd_next   = (addr_next == addr_reg);
                            state_next = ST_FINISH;
                        end
                    end
                    OP_READ: begin
                        rvalid_next = (32'(in_reg.read_row) < SCREEN_ROWS)
                                   && (32'(in_reg.read_column) < SCREEN_COLUMNS);
                        raddr_next  = AW'(32'(in_reg.read_row) * SCREEN_COLUMNS
                                          + 32'(in_reg.read_column));
                        state_next  = ST_FINISH;
                    end
                    OP_CLEAR: begin
                        cnt_next   = '0;
                        row_next   = '0;
                        col_next   = '0;
                        addr_next  = '0;
                        state_next = ST_CLEAR;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCROLL: begin
                if (cnt_reg < CNTW'(MOVED)) begin
                    raddr_next = AW'(cnt_reg + CNTW'(SCREEN_COLUMNS));
                end
                if (cnt_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(cnt_reg - CNTW'(1));
                    ram_wdata = (cnt_reg <= CNTW'(MOVED)) ? ram_rdata : blank;
                end
                if (cnt_reg == CNTW'(CELLS)) begin
                    raddr_next = addr_reg;
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = blank;
                if (cnt_reg == CNTW'(CELLS - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_FINISH: begin
                if (complete) begin
                    if (in_reg.operation == OP_WRITE || in_reg.operation == OP_CLEAR) begin
                        ram_we     = 1'b1;
                        ram_waddr  = addr_reg;
                        ram_wdata  = {cfg.cursor_attribute, CH_SPACE};
                        if (in_reg.operation == OP_WRITE) begin
                            saved_next = fwd_reg ? saved_reg : ram_rdata;
                        end else begin
                            saved_next = blank;
                        end
                    end
                    if (report_reg) begin
                        m_valid_next                  = 1'b1;
                        m_data_next.cell_data         = (in_reg.operation == OP_READ
                                                         && rvalid_reg) ? ram_rdata : 16'd0;
                        m_data_next.cursor_row_out    = 5'(row_reg);
                        m_data_next.cursor_column_out = 7'(col_reg);
                        m_data_next.scrolled          = (in_reg.operation == OP_WRITE)
                                                        && scrolled_reg;
                    end
                    report_next = 1'b1;
                    if (s_valid) begin
                        in_next    = s_data;
                        state_next = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cursor_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |->
            (addr_reg == AW'(32'(row_reg) * SCREEN_COLUMNS + 32'(col_reg))))
        else $error("cursor address out of step with row and column");

    a_scroll_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL) |->
            (row_reg == RW'(SCREEN_ROWS - 1) && col_reg == '0 && scrolled_reg))
        else $error("scroll without cursor on bottom row");

    a_no_result_in_reset_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !report_reg |-> !m_valid_reg)
        else $error("result issued by reset clearing pass");
`endif

endmodule

### sim/tb.sv
module tb;
    import tcw_pkg::*;

    localparam int ROWS = 25;
    localparam int COLS = 80;
    localparam int CELLS = ROWS * COLS;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 140;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tcw_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tcw_out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    logic [15:0] screen_cells [0:CELLS-1];
    int cur_row;
    int cur_col;
    logic [15:0] under_cursor;
    bit cursor_drawn;
    logic [7:0] text_attr;
    logic [7:0] block_attr;

    tcw_out_t console_replies [$];
    tcw_out_t oldest_reply;
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int line_left = 0;

    text_console_writer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #80_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (console_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", m_data));
            end else begin
                oldest_reply = console_replies.pop_front();
                if (m_data.cell_data !== oldest_reply.cell_data ||
                    m_data.cursor_row_out !== oldest_reply.cursor_row_out ||
                    m_data.cursor_column_out !== oldest_reply.cursor_column_out ||
                    m_data.scrolled !== oldest_reply.scrolled)
                    report_mismatch($sformatf(
                        "cell %h/%h row %0d/%0d col %0d/%0d scrolled %b/%b (exp/act)",
                        oldest_reply.cell_data, m_data.cell_data,
                        oldest_reply.cursor_row_out, m_data.cursor_row_out,
                        oldest_reply.cursor_column_out, m_data.cursor_column_out,
                        oldest_reply.scrolled, m_data.scrolled));
            end
        end
    end

    task automatic show_cursor();
        int idx;
        idx = cur_row * COLS + cur_col;
        under_cursor = screen_cells[idx];
        screen_cells[idx] = {block_attr, CH_SPACE};
        cursor_drawn = 1'b1;
    endtask

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++) screen_cells[i] = {text_attr, CH_SPACE};
        cur_row = 0;
        cur_col = 0;
        show_cursor();
    endtask

    task automatic apply_console_op(input tcw_in_t it, output tcw_out_t reply);
        logic scroll;
        scroll = 1'b0;
        reply = '0;
        case (it.operation)
            OP_WRITE: begin
                if (cursor_drawn) begin
                    screen_cells[cur_row * COLS + cur_col] = under_cursor;
                    cursor_drawn = 1'b0;
                end
                if (it.char_code == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (it.char_code == CH_RETURN) begin
                    cur_col = 0;
                end else begin
                    screen_cells[cur_row * COLS + cur_col] = {text_attr, it.char_code};
                    cur_col++;
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLS; i++)
                        screen_cells[i] = screen_cells[i + COLS];
                    for (int c = 0; c < COLS; c++)
                        screen_cells[(ROWS - 1) * COLS + c] = {text_attr, CH_SPACE};
                    cur_row = ROWS - 1;
                    cur_col = 0;
                    scroll = 1'b1;
                end
                show_cursor();
            end
            OP_READ: begin
                if (it.read_row < ROWS && it.read_column < COLS)
                    reply.cell_data = screen_cells[it.read_row * COLS + it.read_column];
            end
            OP_CLEAR: blank_screen();
            default: ;
        endcase
        reply.cursor_row_out = 5'(cur_row);
        reply.cursor_column_out = 7'(cur_col);
        reply.scrolled = scroll;
    endtask

    task automatic send_item(input tcw_in_t it);
        tcw_out_t reply;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!aresetn || s_ready !== 1'b1);
        apply_console_op(it, reply);
        console_replies.push_back(reply);
    endtask

    task automatic wait_until_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (console_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!aresetn || s_ready !== 1'b1) @(posedge aclk);
    endtask

    task automatic set_register(input logic idx, input logic [7:0] value);
        wait_until_idle();
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 2'b00});
        pwdata <= CFG_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (idx == REG_DEFAULT_ATTR) text_attr = value;
        else block_attr = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata[7:0] !== value)
            report_mismatch($sformatf("register %0d read %h, wrote %h", idx, prdata, value));
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic tcw_in_t make_item(input logic [1:0] op, input logic [7:0] ch,
                                          input int row, input int col);
        tcw_in_t it;
        it.operation = op;
        it.char_code = ch;
        it.read_row = 5'(row);
        it.read_column = 7'(col);
        return it;
    endfunction

    function automatic logic [7:0] printable_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_NEWLINE || b == CH_RETURN);
        return b;
    endfunction

    function automatic tcw_in_t random_item();
        tcw_in_t it;
        int pick;
        it = tcw_in_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.operation = OP_WRITE;
            if (line_left == 0) begin
                it.char_code = ($urandom_range(0, 4) == 0) ? CH_RETURN : CH_NEWLINE;
                line_left = $urandom_range(0, 100);
            end else begin
                it.char_code = 8'($urandom);
                line_left--;
            end
        end else if (pick < 95) begin
            it.operation = OP_READ;
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                it.read_row = 5'(cur_row);
                it.read_column = 7'($urandom_range(0, COLS - 1));
            end else if (pick < 7) begin
                it.read_row = 5'(cur_row);
                it.read_column = 7'(cur_col);
            end else if (pick < 9) begin
                it.read_row = 5'($urandom_range(0, ROWS - 1));
                it.read_column = 7'($urandom_range(0, COLS - 1));
            end
        end else if (pick < 97) begin
            it.operation = OP_CLEAR;
        end else begin
            it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic test_reset_screen();
        send_item(make_item(OP_READ, 8'hFF, 0, 0));
        send_item(make_item(OP_READ, 8'h00, ROWS - 1, COLS - 1));
        send_item(make_item(OP_READ, 8'h00, ROWS, 0));
        send_item(make_item(OP_READ, 8'h00, 0, COLS));
        send_item(make_item(OP_READ, 8'h00, 31, 127));
        send_item(make_item(OP_UNUSED, 8'hFF, 31, 127));
    endtask

    task automatic test_character_codes();
        send_item(make_item(OP_WRITE, 8'h00, 31, 127));
        send_item(make_item(OP_WRITE, 8'hFF, 0, 0));
        send_item(make_item(OP_WRITE, 8'h41, 0, 0));
        for (int c = 0; c < 4; c++) send_item(make_item(OP_READ, 8'h00, 0, c));
        send_item(make_item(OP_WRITE, CH_RETURN, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 0, 0));
        send_item(make_item(OP_WRITE, CH_NEWLINE, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 1, 0));
        send_item(make_item(OP_CLEAR, 8'h00, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 0, 1));
    endtask

    task automatic test_attributes();
        set_register(REG_DEFAULT_ATTR, 8'h00);
        set_register(REG_CURSOR_ATTR, 8'h00);
        send_item(make_item(OP_WRITE, 8'h5A, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 0, 1));
        set_register(REG_DEFAULT_ATTR, 8'hFF);
        set_register(REG_CURSOR_ATTR, 8'hFF);
        send_item(make_item(OP_READ, 8'h00, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 0, 1));
        send_item(make_item(OP_WRITE, 8'hA5, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 0, 1));
        send_item(make_item(OP_READ, 8'h00, 0, 2));
        send_item(make_item(OP_CLEAR, 8'h00, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 7, 9));
        set_register(REG_DEFAULT_ATTR, 8'h1E);
        set_register(REG_CURSOR_ATTR, 8'h70);
    endtask

    task automatic test_wrap_and_scroll();
        send_item(make_item(OP_CLEAR, 8'($urandom), 0, 0));
        repeat (COLS + 5) send_item(make_item(OP_WRITE, printable_byte(), 0, 0));
        send_item(make_item(OP_READ, 8'($urandom), 0, COLS - 1));
        send_item(make_item(OP_READ, 8'($urandom), 1, 0));
        send_item(make_item(OP_READ, 8'($urandom), 1, 5));
        repeat (ROWS + 3) begin
            send_item(make_item(OP_WRITE, printable_byte(), 0, 0));
            send_item(make_item(OP_WRITE, CH_NEWLINE, 0, 0));
        end
        send_item(make_item(OP_READ, 8'($urandom), ROWS - 1, 0));
        send_item(make_item(OP_READ, 8'($urandom), ROWS - 2, 0));
        send_item(make_item(OP_READ, 8'($urandom), 0, 0));
        repeat (COLS + 3) send_item(make_item(OP_WRITE, printable_byte(), 0, 0));
        send_item(make_item(OP_READ, 8'($urandom), ROWS - 2, COLS - 1));
        send_item(make_item(OP_READ, 8'($urandom), ROWS - 1, 1));
        send_item(make_item(OP_WRITE, CH_RETURN, 0, 0));
        send_item(make_item(OP_READ, 8'($urandom), ROWS - 1, 2));
    endtask

    task automatic test_random_traffic();
        int idle_pct [4] = '{0, 78, 0, 16};
        int stall_pct [4] = '{0, 0, 78, 16};
        for (int ph = 0; ph < 4; ph++) begin
            set_register(REG_DEFAULT_ATTR, 8'($urandom));
            set_register(REG_CURSOR_ATTR, 8'($urandom));
            send_idle_pct = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        text_attr = DEFAULT_ATTR_RESET;
        block_attr = CURSOR_ATTR_RESET;
        cursor_drawn = 1'b0;
        under_cursor = '0;
        blank_screen();
        recv_stall_pct = 30;
        test_reset_screen();
        test_character_codes();
        test_attributes();
        test_wrap_and_scroll();
        test_random_traffic();
        wait_until_idle();
        if (mismatch_count == 0 && console_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_cfg.sv
rtl/core/text_console_writer.sv
sim/tb.sv
